// ----- hdl/frame_fifo_with_drop_core_assert.svh -----
// Assertion macros for the frame FIFO core.
// Used by frame_fifo_with_drop_core; the clock is clk and the reset is rst.
`ifndef FRAME_FIFO_WITH_DROP_CORE_ASSERT_SVH
`define FRAME_FIFO_WITH_DROP_CORE_ASSERT_SVH

// same-cycle implication
`define FFD_CHECK(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame fifo check failed");

// next-cycle implication
`define FFD_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame fifo check failed (next cycle)");

`endif

// ----- hdl/ffd_pkg.sv -----
// Shared types and codes for the frame FIFO core.
// No dependencies.
package ffd_pkg;

  localparam int DEF_SLOTS      = 8;
  localparam int DEF_SLOT_BYTES = 4096;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  localparam logic [2:0] ST_TAKEN  = 3'd0;
  localparam logic [2:0] ST_COMMIT = 3'd1;
  localparam logic [2:0] ST_REJECT = 3'd2;
  localparam logic [2:0] ST_BYTE   = 3'd3;
  localparam logic [2:0] ST_EMPTY  = 3'd4;
  localparam logic [2:0] ST_DROP   = 3'd5;

  typedef struct packed {
    logic        func;
    logic [7:0]  data;
    logic        last;
    logic [15:0] capacity;
  } item_t;

endpackage

// ----- hdl/frame_fifo_with_drop_core.sv -----
// Top level of the store-and-forward frame FIFO with whole-frame drop.
// Depends on ffd_pkg, ffd_front, ffd_back, ffd_ram and the assertion header.
//
//   channel   handshake          payload
//   input     start / busy       func, in_byte, in_last, capacity
//   result    done (1 cycle)     status, out_byte, out_last, head_size, frames_queued
//
// An item is queued in a 2-entry queue, then taken in S_IDLE and executed in S_EXEC,
// followed by S_SIZE when it frees the head slot (to fetch the new head's size).
// A queued item waits for the ones ahead: the back end takes the next item only
// once it is through with the current one. busy is high while the queue is full;
// done cannot be held off.
// Synchronous reset empties the ring; frame bytes and slot sizes are left uninitialized.
`include "frame_fifo_with_drop_core_assert.svh"

module frame_fifo_with_drop_core #(
  parameter int SLOTS      = ffd_pkg::DEF_SLOTS,
  parameter int SLOT_BYTES = ffd_pkg::DEF_SLOT_BYTES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            func,
  input  logic [7:0]                      in_byte,
  input  logic                            in_last,
  input  logic [15:0]                     capacity,
  output logic                            done,
  output logic [2:0]                      status,
  output logic [7:0]                      out_byte,
  output logic                            out_last,
  output logic [$clog2(SLOT_BYTES+1)-1:0] head_size,
  output logic [$clog2(SLOTS+1)-1:0]      frames_queued
);
  import ffd_pkg::*;

  logic  item_valid;
  item_t item;
  logic  pop;

  ffd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .func       (func),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .capacity   (capacity),
    .item_valid (item_valid),
    .item       (item),
    .pop        (pop)
  );

  ffd_back #(.SLOTS(SLOTS), .SLOT_BYTES(SLOT_BYTES)) u_back (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item          (item),
    .pop           (pop),
    .done          (done),
    .status        (status),
    .out_byte      (out_byte),
    .out_last      (out_last),
    .head_size     (head_size),
    .frames_queued (frames_queued)
  );

  `FFD_CHECK(a_count_bound, done, 32'(frames_queued) <= SLOTS)
  `FFD_CHECK(a_empty_clean, done && status == ST_EMPTY, frames_queued == '0 && head_size == '0)
  `FFD_CHECK(a_no_head_size, done && frames_queued == '0, head_size == '0)
  `FFD_CHECK(a_byte_only_on_read, done && status != ST_BYTE, out_byte == 8'd0 && !out_last)
  `FFD_CHECK_NEXT(a_pop_single, pop, !pop)

endmodule

// ----- hdl/ffd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/ffd_front.sv -----
// Front end: takes command items and queues them for the back end.
// Depends on ffd_pkg.
module ffd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  logic          func,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  input  logic [15:0]   capacity,
  output logic          item_valid,
  output ffd_pkg::item_t item,
  input  logic          pop
);
  import ffd_pkg::*;

  item_t      q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       push;

  assign busy       = (cnt == 2'd2);
  assign push       = start && !busy;
  assign item_valid = (cnt != 2'd0);
  assign item       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{func: func, data: in_byte, last: in_last, capacity: capacity};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

// ----- hdl/ffd_back.sv -----
// Back end: executes queued push/read items against the slot ring.
// Depends on ffd_pkg and ffd_ram.
module ffd_back #(
  parameter int SLOTS      = ffd_pkg::DEF_SLOTS,
  parameter int SLOT_BYTES = ffd_pkg::DEF_SLOT_BYTES
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  input  ffd_pkg::item_t                     item,
  output logic                               pop,
  output logic                               done,
  output logic [2:0]                         status,
  output logic [7:0]                         out_byte,
  output logic                               out_last,
  output logic [$clog2(SLOT_BYTES+1)-1:0]    head_size,
  output logic [$clog2(SLOTS+1)-1:0]         frames_queued
);
  import ffd_pkg::*;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SIZE_W = $clog2(SLOT_BYTES + 1);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int TOTAL  = SLOTS * SLOT_BYTES;
  localparam int ADDR_W = $clog2(TOTAL);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
  localparam logic [ADDR_W-1:0] LAST_BASE = ADDR_W'((SLOTS - 1) * SLOT_BYTES);
  localparam logic [ADDR_W-1:0] BASE_STEP = ADDR_W'(SLOT_BYTES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SIZE = 2'd2;

  logic [1:0]        state, state_next;
  item_t             cur, cur_next;
  logic [SLOT_W-1:0] head_slot, head_slot_next, tail_slot, tail_slot_next;
  logic [ADDR_W-1:0] head_base, head_base_next, tail_base, tail_base_next;
  logic [CNT_W-1:0]  frame_count, frame_count_next;
  logic [SIZE_W-1:0] write_offset, write_offset_next;
  logic              write_rejecting, write_rejecting_next;
  logic [SIZE_W-1:0] read_offset, read_offset_next;
  logic              read_active, read_active_next;
  logic [SIZE_W-1:0] hsize, hsize_next;

  logic [2:0]        st;
  logic [7:0]        ob;
  logic              ol;
  logic              free;
  logic              rej;
  logic [SIZE_W-1:0] wsize, rsize;

  logic              store_we;
  logic [ADDR_W-1:0] store_waddr, store_raddr;
  logic [7:0]        store_rdata;
  logic              size_we;
  logic [SLOT_W-1:0] size_raddr;
  logic [SIZE_W-1:0] size_rdata;

  ffd_ram #(.WIDTH(8), .DEPTH(TOTAL)) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (cur.data),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  ffd_ram #(.WIDTH(SIZE_W), .DEPTH(SLOTS)) u_sizes (
    .clk   (clk),
    .we    (size_we),
    .waddr (tail_slot),
    .wdata (wsize),
    .raddr (size_raddr),
    .rdata (size_rdata)
  );

  assign wsize       = write_offset + SIZE_W'(1);
  assign rsize       = read_offset + SIZE_W'(1);
  assign store_raddr = head_base + ADDR_W'(read_offset);
  assign store_waddr = tail_base + ADDR_W'(write_offset);

  always_comb begin
    state_next           = state;
    cur_next             = cur;
    head_slot_next       = head_slot;
    tail_slot_next       = tail_slot;
    head_base_next       = head_base;
    tail_base_next       = tail_base;
    frame_count_next     = frame_count;
    write_offset_next    = write_offset;
    write_rejecting_next = write_rejecting;
    read_offset_next     = read_offset;
    read_active_next     = read_active;
    hsize_next           = hsize;
    st                   = ST_TAKEN;
    ob                   = 8'd0;
    ol                   = 1'b0;
    free                 = 1'b0;
    rej                  = 1'b0;
    store_we             = 1'b0;
    size_we              = 1'b0;
    pop                  = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          pop        = 1'b1;
          cur_next   = item;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cur.func == FUNC_PUSH) begin
          rej = write_rejecting ||
                (write_offset == '0 && frame_count >= CNT_W'(SLOTS)) ||
                (write_offset >= SIZE_W'(SLOT_BYTES));
          if (rej) begin
            write_offset_next    = '0;
            write_rejecting_next = !cur.last;
            st                   = ST_REJECT;
          end else begin
            store_we = 1'b1;
            if (cur.last) begin
              size_we           = 1'b1;
              tail_slot_next    = (tail_slot == LAST_SLOT) ? '0 : tail_slot + SLOT_W'(1);
              tail_base_next    = (tail_base == LAST_BASE) ? '0 : tail_base + BASE_STEP;
              frame_count_next  = frame_count + CNT_W'(1);
              write_offset_next = '0;
              if (frame_count == '0) begin
                hsize_next = wsize;
              end
              st = ST_COMMIT;
            end else begin
              write_offset_next = wsize;
              st                = ST_TAKEN;
            end
          end
        end else begin
          if (!read_active && frame_count == '0) begin
            st = ST_EMPTY;
          end else if (!read_active && 32'(cur.capacity) < 32'(hsize)) begin
            free = 1'b1;
            st   = ST_DROP;
          end else begin
            ob               = store_rdata;
            st               = ST_BYTE;
            read_active_next = 1'b1;
            read_offset_next = rsize;
            if (rsize >= hsize) begin
              ol   = 1'b1;
              free = 1'b1;
            end
          end
        end
        if (free) begin
          head_slot_next   = (head_slot == LAST_SLOT) ? '0 : head_slot + SLOT_W'(1);
          head_base_next   = (head_base == LAST_BASE) ? '0 : head_base + BASE_STEP;
          frame_count_next = frame_count - CNT_W'(1);
          read_active_next = 1'b0;
          read_offset_next = '0;
          state_next       = S_SIZE;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SIZE: begin
        hsize_next = size_rdata;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase

    size_raddr = head_slot_next;
  end

  always_ff @(posedge clk) begin
    cur   <= cur_next;
    hsize <= hsize_next;
    if (state == S_EXEC) begin
      status        <= st;
      out_byte      <= ob;
      out_last      <= ol;
      head_size     <= (frame_count_next != '0) ? hsize_next : '0;
      frames_queued <= frame_count_next;
    end else if (state == S_SIZE) begin
      head_size <= (frame_count != '0) ? size_rdata : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      head_slot       <= '0;
      tail_slot       <= '0;
      head_base       <= '0;
      tail_base       <= '0;
      frame_count     <= '0;
      write_offset    <= '0;
      write_rejecting <= 1'b0;
      read_offset     <= '0;
      read_active     <= 1'b0;
      done            <= 1'b0;
    end else begin
      state           <= state_next;
      head_slot       <= head_slot_next;
      tail_slot       <= tail_slot_next;
      head_base       <= head_base_next;
      tail_base       <= tail_base_next;
      frame_count     <= frame_count_next;
      write_offset    <= write_offset_next;
      write_rejecting <= write_rejecting_next;
      read_offset     <= read_offset_next;
      read_active     <= read_active_next;
      done            <= ((state == S_EXEC) && !free) || (state == S_SIZE);
    end
  end

endmodule
